[rtl/sliding_window_drift_detector_unit_macros.svh]
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef SLIDING_WINDOW_DRIFT_DETECTOR_UNIT_MACROS_SVH
`define SLIDING_WINDOW_DRIFT_DETECTOR_UNIT_MACROS_SVH

`ifndef SYNTH
`define SWDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SWDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SWDD_ASSERT(lbl, prop, msg)
`define SWDD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/swdd_pkg.sv]
package swdd_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

  localparam int SCORE_W  = 16;
  localparam int WLEN_W   = 7;
  localparam int FRAC_W   = 17;
  localparam int FILL_W   = 7;
  localparam int VERD_W   = 2;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int ONE_SHIFT = 16;

  typedef logic signed [SCORE_W-1:0] score_t;

  // operation codes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // verdict codes
  localparam logic [VERD_W-1:0] VERDICT_NORMAL = 2'd0;
  localparam logic [VERD_W-1:0] VERDICT_FAULT  = 2'd1;
  localparam logic [VERD_W-1:0] VERDICT_DRIFT  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_WINDOW_LEN     = 2'd0;
  localparam logic [1:0] REG_FAULT_LIMIT    = 2'd1;
  localparam logic [1:0] REG_DRIFT_LIMIT    = 2'd2;
  localparam logic [1:0] REG_DRIFT_FRACTION = 2'd3;

  // count token walking down the cell row
  typedef struct packed {
    logic             vld;
    logic [CNT_W-1:0] rem;
    logic [CNT_W-1:0] cnt;
  } swdd_token_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } swdd_state_t;

endpackage

[rtl/swdd_if.sv]
interface swdd_in_if import swdd_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   operation;
  score_t score;

  modport source (output valid, output operation, output score, input ready);
  modport sink   (input valid, input operation, input score, output ready);
endinterface

interface swdd_out_if import swdd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VERD_W-1:0] verdict;
  logic [FILL_W-1:0] window_fill;

  modport source (output valid, output verdict, output window_fill, input ready);
  modport sink   (input valid, input verdict, input window_fill, output ready);
endinterface

[rtl/sliding_window_drift_detector_unit.sv]
// channel   | dir | payload                          | handshake
// in_ch     | in  | operation, score                 | valid/ready
// out_ch    | out | verdict, window_fill             | valid/ready
// cfg_*     | in  | apb regs window_len..fraction    | psel/penable, pready tied high
//
// a push loads its result once the count token, registered in head_tok_r, has crossed
// the row of WINDOW_MAX cells one cell per cycle and the sequencer has reached ST_DONE
// a clear goes straight to ST_DONE; in_ready returns the cycle after the
// load, so no new beat is taken before the last result is loaded
// reset is synchronous, active low; no clearing pass, the fill count masks old cells
// a stalled output only delays the load of the next result, nothing is dropped
`include "sliding_window_drift_detector_unit_macros.svh"

module sliding_window_drift_detector_unit import swdd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  swdd_in_if.sink           in_ch,
  swdd_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int PROD_W = FRAC_W + CNT_W;

  // config registers
  logic [WLEN_W-1:0] wlen_r;
  score_t            fault_r;
  score_t            drift_r;
  logic [FRAC_W-1:0] frac_r;

  // window and control state
  swdd_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  fill_r;
  logic              fault_hit_r;
  logic [VERD_W-1:0] pend_r;
  swdd_token_t       head_tok_r;
  swdd_token_t       tail_tok;

  // output register
  logic              out_valid_r;
  logic [VERD_W-1:0] out_verdict_r;
  logic [FILL_W-1:0] out_fill_r;

  logic              cfg_wr;
  logic [1:0]        cfg_idx;
  logic              in_ready;
  logic              in_acc;
  logic              push_acc;
  logic              clear_acc;
  logic              out_free;
  logic              load_out;
  logic [CNT_W-1:0]  eff_len;
  logic [CNT_W-1:0]  fill_push;
  logic [PROD_W-1:0] lhs;
  logic [PROD_W-1:0] rhs;
  logic [VERD_W-1:0] walk_verdict;

  // ---------------------------------------------------------------- config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r  <= WLEN_W'(WINDOW_MAX);
      fault_r <= 16'sh7fff;
      drift_r <= 16'sh7fff;
      frac_r  <= FRAC_W'(1 << ONE_SHIFT);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WINDOW_LEN:     wlen_r  <= cfg_pwdata[WLEN_W-1:0];
        REG_FAULT_LIMIT:    fault_r <= signed'(cfg_pwdata[SCORE_W-1:0]);
        REG_DRIFT_LIMIT:    drift_r <= signed'(cfg_pwdata[SCORE_W-1:0]);
        REG_DRIFT_FRACTION: frac_r  <= cfg_pwdata[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WINDOW_LEN:     cfg_prdata = DATA_W'(wlen_r);
      REG_FAULT_LIMIT:    cfg_prdata = DATA_W'({16'h0000, fault_r});
      REG_DRIFT_LIMIT:    cfg_prdata = DATA_W'({16'h0000, drift_r});
      REG_DRIFT_FRACTION: cfg_prdata = DATA_W'(frac_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // length zero acts as one, anything past the row acts as the full row
  always_comb begin
    if (wlen_r == '0) begin
      eff_len = CNT_W'(1);
    end else if (int'(wlen_r) > WINDOW_MAX) begin
      eff_len = CNT_W'(WINDOW_MAX);
    end else begin
      eff_len = CNT_W'(wlen_r);
    end
  end

  // ---------------------------------------------------------------- handshakes
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_ch.valid && in_ready;
  assign push_acc  = in_acc && (in_ch.operation == OP_PUSH);
  assign clear_acc = in_acc && (in_ch.operation == OP_CLEAR);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign fill_push = (fill_r < eff_len) ? fill_r + CNT_W'(1) : fill_r;

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.verdict     = out_verdict_r;
  assign out_ch.window_fill = out_fill_r;

  // ---------------------------------------------------------------- cell row
  swdd_chain u_chain (
    .clk         (clk),
    .rst_n       (rst_n),
    .shift_en    (push_acc),
    .score_in    (in_ch.score),
    .drift_limit (drift_r),
    .head_tok    (head_tok_r),
    .tail_tok    (tail_tok)
  );

  // drift when above * 65536 > fraction * fill
  assign lhs = PROD_W'({tail_tok.cnt, 16'h0000});
  assign rhs = PROD_W'(frac_r) * PROD_W'(fill_r);

  always_comb begin
    if (fault_hit_r) begin
      walk_verdict = VERDICT_FAULT;
    end else if (lhs > rhs) begin
      walk_verdict = VERDICT_DRIFT;
    end else begin
      walk_verdict = VERDICT_NORMAL;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_ch.operation == OP_CLEAR) ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        if (tail_tok.vld) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // fill count; a window length write empties the window too
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cfg_wr && (cfg_idx == REG_WINDOW_LEN)) begin
      fill_r <= '0;
    end else if (clear_acc) begin
      fill_r <= '0;
    end else if (push_acc) begin
      fill_r <= fill_push;
    end
  end

  // token enters cell 0 the cycle after the new score is shifted in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_tok_r <= '0;
    end else begin
      head_tok_r.vld <= push_acc;
      head_tok_r.rem <= fill_push;
      head_tok_r.cnt <= '0;
    end
  end

  // pending result, payload only
  always_ff @(posedge clk) begin
    if (push_acc) begin
      fault_hit_r <= (in_ch.score > fault_r);
    end
    if (clear_acc) begin
      pend_r <= VERDICT_NORMAL;
    end else if ((state_r == ST_WALK) && tail_tok.vld) begin
      pend_r <= walk_verdict;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_verdict_r <= pend_r;
      out_fill_r    <= FILL_W'(fill_r);
    end
  end

  // ---------------------------------------------------------------- checks
  `SWDD_ASSERT(a_tail_in_walk, tail_tok.vld |-> (state_r == ST_WALK), "token left row outside walk")
  `SWDD_ASSERT(a_fill_bound, fill_r <= eff_len, "fill count above window length")
  `SWDD_ASSERT_NEXT(a_push_starts_walk, push_acc, head_tok_r.vld && (state_r == ST_WALK), "push did not start walk")
  `SWDD_ASSERT_NEXT(a_done_loads, (state_r == ST_DONE) && out_free, out_valid_r && (state_r == ST_IDLE), "result not loaded")

endmodule

[rtl/swdd_cell.sv]
module swdd_cell import swdd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        shift_en,
  input  score_t      score_in,
  input  score_t      drift_limit,
  input  swdd_token_t tok_in,
  output score_t      score_out,
  output swdd_token_t tok_out
);

  score_t      score_r;
  swdd_token_t tok_r;
  swdd_token_t tok_nxt;

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.rem != '0) begin
      tok_nxt.rem = tok_in.rem - CNT_W'(1);
      if (score_r > drift_limit) begin
        tok_nxt.cnt = tok_in.cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      score_r <= score_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign score_out = score_r;
  assign tok_out   = tok_r;

endmodule

[rtl/swdd_chain.sv]
module swdd_chain import swdd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        shift_en,
  input  score_t      score_in,
  input  score_t      drift_limit,
  input  swdd_token_t head_tok,
  output swdd_token_t tail_tok
);

  score_t      score_link [WINDOW_MAX+1];
  swdd_token_t tok_link   [WINDOW_MAX+1];

  assign score_link[0] = score_in;
  assign tok_link[0]   = head_tok;

  // newest score sits in cell 0, oldest valid one in cell fill-1
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swdd_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .shift_en    (shift_en),
      .score_in    (score_link[i]),
      .drift_limit (drift_limit),
      .tok_in      (tok_link[i]),
      .score_out   (score_link[i+1]),
      .tok_out     (tok_link[i+1])
    );
  end

  assign tail_tok = tok_link[WINDOW_MAX];

endmodule

[dv/sliding_window_drift_detector_unit_test.sv]
`timescale 1ns / 1ps

module sliding_window_drift_detector_unit_test;
  import swdd_pkg::*;

  // stimulus phase flavors for the random part
  typedef enum int {
    PHASE_PLAIN,
    PHASE_HOLD,
    PHASE_DRAIN,
    PHASE_QUIET
  } phase_mode_t;

  // one expected result beat
  typedef struct packed {
    logic [VERD_W-1:0] verdict;
    logic [FILL_W-1:0] fill;
  } verdict_beat_t;

  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst_n;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  swdd_in_if  in_ch ();
  swdd_out_if out_ch ();

  sliding_window_drift_detector_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shadow copy of the register file
  logic [WLEN_W-1:0] win_len_reg;
  score_t            fault_lim;
  score_t            drift_lim;
  logic [FRAC_W-1:0] drift_frac;

  // shadow copy of the score window
  score_t win_scores [WINDOW_MAX];
  int     win_wr_pos;
  int     win_fill;

  // verdicts still owed by the block, oldest first
  verdict_beat_t verdicts_due [$];

  int fail_cnt;
  bit idle_on;    // random gaps on both sides when set
  int hold_req;   // bumped by the stimulus to ask for a long output hold-off

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // hard stop in case the block hangs
  initial begin
    #(20_000_000);
    $display("sliding_window_drift_detector_unit test failed");
    $finish;
  end

  // mostly short gaps, a few long ones, none while idling is off
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // next verdict for one accepted beat, advancing the shadow window
  function automatic verdict_beat_t predict_verdict(logic op, score_t s);
    verdict_beat_t res;
    int len;
    int wp;
    int above;
    len = (win_len_reg == 0) ? 1 : (win_len_reg > WINDOW_MAX) ? WINDOW_MAX : int'(win_len_reg);
    res.verdict = VERDICT_NORMAL;
    if (op == OP_CLEAR) begin
      win_wr_pos = 0;
      win_fill   = 0;
    end else begin
      // ring write, oldest score dropped once the window is full
      wp = (win_wr_pos < len) ? win_wr_pos : 0;
      if (win_fill > len) win_fill = len;
      win_scores[wp] = s;
      win_wr_pos = (wp + 1 >= len) ? 0 : wp + 1;
      if (win_fill < len) win_fill++;
      if (s > fault_lim) begin
        // fault wins, the score still stays in the window
        res.verdict = VERDICT_FAULT;
      end else begin
        above = 0;
        for (int i = 0; i < win_fill; i++)
          if (win_scores[i] > drift_lim) above++;
        // exact fraction test: above / fill > frac / 65536
        if (64'(above) * 64'd65536 > 64'(drift_frac) * 64'(win_fill))
          res.verdict = VERDICT_DRIFT;
      end
    end
    res.fill = FILL_W'(win_fill);
    return res;
  endfunction

  // stop offering beats and wait until every verdict has come back
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write, setup then access phase, only with the block idle
  task automatic write_reg(logic [1:0] idx, logic [DATA_W-1:0] val);
    wait_drain();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_WINDOW_LEN: begin
        // a new length restarts the window
        win_len_reg = val[WLEN_W-1:0];
        win_wr_pos  = 0;
        win_fill    = 0;
      end
      REG_FAULT_LIMIT:    fault_lim  = score_t'(val[SCORE_W-1:0]);
      REG_DRIFT_LIMIT:    drift_lim  = score_t'(val[SCORE_W-1:0]);
      REG_DRIFT_FRACTION: drift_frac = val[FRAC_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // offer one beat after a random gap, predict at acceptance
  task automatic send_beat(logic op, score_t s);
    int gap;
    gap = pick_pause();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.score     <= s;
    do @(posedge clk); while (!in_ch.ready);
    verdicts_due.push_back(predict_verdict(op, s));
  endtask

  // result side: random stalls, long hold-off on request, checks each beat
  initial begin
    int stall_left;
    int hold_left;
    int hold_seen;
    verdict_beat_t due;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result beat, verdict %0d fill %0d", $time,
                   out_ch.verdict, out_ch.window_fill);
          fail_cnt++;
        end else begin
          due = verdicts_due.pop_front();
          if (out_ch.verdict !== due.verdict) begin
            $display("%0t: verdict mismatch, expected %0d, actual %0d", $time,
                     due.verdict, out_ch.verdict);
            fail_cnt++;
          end
          if (out_ch.window_fill !== due.fill) begin
            $display("%0t: window_fill mismatch, expected %0d, actual %0d", $time,
                     due.fill, out_ch.window_fill);
            fail_cnt++;
          end
        end
      end
      // a long hold-off is counted here, the sender keeps offering meanwhile
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_pause();
      end
    end
  end

  // score near the drift limit with a bias, sometimes near the fault limit or anywhere
  function automatic score_t pick_score(int bias);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return score_t'($urandom);
    if (r < 18) return score_t'(int'(fault_lim) + int'($urandom_range(0, 8)) - 4);
    return score_t'(int'(drift_lim) + bias + int'($urandom_range(0, 256)) - 128);
  endfunction

  // reset values: limits at max so no fault and no drift, window fill count grows
  task automatic test_reset_state();
    send_beat(OP_PUSH, 16'sh7fff);
    send_beat(OP_PUSH, 16'sh8000);
    send_beat(OP_PUSH, 16'sh0000);
  endtask

  // scores right at and around both limits, ring wrap, clear
  task automatic test_threshold_edges();
    write_reg(REG_WINDOW_LEN, 32'd4);
    write_reg(REG_FAULT_LIMIT, 32'h0000_0100);
    write_reg(REG_DRIFT_LIMIT, 32'h0000_0080);
    write_reg(REG_DRIFT_FRACTION, 32'd32768);
    send_beat(OP_PUSH, 16'sh0081);   // one above out of one
    send_beat(OP_PUSH, 16'sh0080);   // equal to drift limit, exactly half above
    send_beat(OP_PUSH, 16'sh8000);
    send_beat(OP_PUSH, 16'sh0100);   // equal to fault limit, no fault
    send_beat(OP_PUSH, 16'sh0101);   // fault, overwrites the oldest
    send_beat(OP_PUSH, 16'sh7fff);
    send_beat(OP_CLEAR, 16'sh7fff);  // score ignored on clear
    send_beat(OP_CLEAR, 16'sh0000);  // clear of an empty window
    send_beat(OP_PUSH, 16'sh00ff);
  endtask

  // fraction at zero and above one, limits at the bottom of the range
  task automatic test_fraction_extremes();
    write_reg(REG_DRIFT_FRACTION, 32'd0);
    send_beat(OP_PUSH, 16'sh8000);   // 0x00ff still in the window is above, so drift at fraction zero
    send_beat(OP_PUSH, 16'sh0081);
    write_reg(REG_FAULT_LIMIT, 32'h0000_7fff);
    write_reg(REG_DRIFT_FRACTION, 32'h0001_ffff);
    send_beat(OP_PUSH, 16'sh7fff);   // three of four above but drift can't fire
    write_reg(REG_FAULT_LIMIT, 32'h0000_8000);
    write_reg(REG_DRIFT_LIMIT, 32'h0000_8000);
    write_reg(REG_DRIFT_FRACTION, 32'd65536);
    send_beat(OP_PUSH, 16'sh8000);   // lowest score, neither limit passed
    send_beat(OP_PUSH, 16'sh8001);   // fault at the lowest limit
  endtask

  // length zero acts as one, above max acts as max, a write empties the window
  task automatic test_window_len_extremes();
    write_reg(REG_FAULT_LIMIT, 32'h0000_7fff);
    write_reg(REG_DRIFT_FRACTION, 32'd0);
    write_reg(REG_WINDOW_LEN, 32'd0);
    send_beat(OP_PUSH, 16'sh8001);
    send_beat(OP_PUSH, 16'sh8000);
    write_reg(REG_WINDOW_LEN, 32'd127);
    send_beat(OP_PUSH, 16'sh1234);
    send_beat(OP_PUSH, 16'sh8000);
    write_reg(REG_WINDOW_LEN, 32'd127);
    send_beat(OP_PUSH, 16'sh8000);
  endtask

  // one phase: random settings changes, then pushes with drifting levels and a few clears
  task automatic run_random_phase(int n_items, phase_mode_t mode);
    int r;
    int bias;
    int sel;
    if ($urandom_range(0, 3) != 0) begin
      sel = $urandom_range(0, 7);
      case (sel)
        0: r = 0;
        1: r = 1;
        2: r = 127;
        3: r = 64;
        4: r = $urandom_range(0, 127);
        default: r = $urandom_range(2, 12);
      endcase
      write_reg(REG_WINDOW_LEN, 32'(r));
    end
    if ($urandom_range(0, 2) != 0) begin
      sel = $urandom_range(0, 5);
      case (sel)
        0: r = 32767;
        1: r = -32768;
        2: r = int'($urandom_range(0, 65535)) - 32768;
        default: r = $urandom_range(1024, 32767);
      endcase
      write_reg(REG_FAULT_LIMIT, 32'(r) & 32'h0000_ffff);
    end
    if ($urandom_range(0, 2) != 0) begin
      sel = $urandom_range(0, 5);
      case (sel)
        0: r = 32767;
        1: r = -32768;
        2: r = int'($urandom_range(0, 65535)) - 32768;
        default: r = int'($urandom_range(0, 2048)) - 1024;
      endcase
      write_reg(REG_DRIFT_LIMIT, 32'(r) & 32'h0000_ffff);
    end
    if ($urandom_range(0, 2) != 0) begin
      sel = $urandom_range(0, 7);
      case (sel)
        0: r = 0;
        1: r = 65536;
        2: r = 65537;
        3: r = 131071;
        4: r = $urandom_range(0, 131071);
        default: r = $urandom_range(0, 65536);
      endcase
      write_reg(REG_DRIFT_FRACTION, 32'(r));
    end

    idle_on = (mode != PHASE_QUIET);
    bias = 0;
    for (int k = 0; k < n_items; k++) begin
      // output held off long enough that the input side backs up
      if (mode == PHASE_HOLD && k == 5) hold_req++;
      // sender pause until every result is back
      if (mode == PHASE_DRAIN && k == n_items / 2) wait_drain();
      // level of the scores wanders above and below the drift limit
      if ($urandom_range(0, 19) == 0) bias = int'($urandom_range(0, 400)) - 200;
      if ($urandom_range(0, 99) < 3)
        send_beat(OP_CLEAR, score_t'($urandom));
      else
        send_beat(OP_PUSH, pick_score(bias));
    end
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 14; p++) begin
      case (p)
        3:       run_random_phase(100, PHASE_HOLD);
        6:       run_random_phase(100, PHASE_DRAIN);
        9:       run_random_phase(100, PHASE_QUIET);
        11:      run_random_phase(100, PHASE_HOLD);
        default: run_random_phase(100, PHASE_PLAIN);
      endcase
    end
  endtask

  initial begin
    fail_cnt    = 0;
    idle_on     = 1'b1;
    hold_req    = 0;
    win_len_reg = WLEN_W'(WINDOW_MAX);
    fault_lim   = 16'sh7fff;
    drift_lim   = 16'sh7fff;
    drift_frac  = FRAC_W'(65536);
    win_wr_pos  = 0;
    win_fill    = 0;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_PUSH;
    in_ch.score     <= '0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_threshold_edges();
    test_fraction_extremes();
    test_window_len_extremes();
    test_random_traffic();

    // everything back, then a quiet tail to catch stray beats
    wait_drain();
    repeat (WINDOW_MAX + 16) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("sliding_window_drift_detector_unit test passed");
    end else begin
      $display("sliding_window_drift_detector_unit test failed");
    end
    $finish;
  end

endmodule
